// File: rtl/bsfn_pkg.sv
package bsfn_pkg;

	localparam int ELEM_W     = 10;
	localparam int SIZE_W     = 11;
	localparam int WORD_IDX_W = 7;
	localparam int OFF_W      = 6;
	localparam int SCAN_W     = 12;
	localparam int TZ_W       = 7;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = 1;

	typedef logic [ELEM_W-1:0]     elem_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [WORD_IDX_W-1:0] word_idx_t;
	typedef logic [OFF_W-1:0]      off_t;
	typedef logic [SCAN_W-1:0]     scan_t;
	typedef logic [TZ_W-1:0]       tz_t;
	typedef logic [Q_PTR_W:0]      q_cnt_t;

	localparam logic [2:0] OP_FILL       = 3'd0;
	localparam logic [2:0] OP_ADD        = 3'd1;
	localparam logic [2:0] OP_REMOVE     = 3'd2;
	localparam logic [2:0] OP_TEST       = 3'd3;
	localparam logic [2:0] OP_FIND_SET   = 3'd4;
	localparam logic [2:0] OP_FIND_CLEAR = 3'd5;

	localparam size_t SIZE_RESET = 11'd1024;

	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_FILL,
		CLS_ADD,
		CLS_REMOVE,
		CLS_TEST,
		CLS_FIND
	} cmd_cls_t;

	typedef struct packed {
		cmd_cls_t  cls;
		logic      want_set;
		logic      in_range;
		elem_t     element;
		word_idx_t word;
		off_t      off;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ACCESS,
		BK_SCAN,
		BK_FILL
	} bk_state_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_status_t;

	// trailing zero count, valid for a nonzero word
	function automatic tz_t ctz64(input logic [63:0] x);
		logic [63:0] v;
		tz_t         n;
		v = x;
		n = '0;
		if (v[31:0] == 32'd0) begin
			n = n + tz_t'(32);
			v = v >> 32;
		end
		if (v[15:0] == 16'd0) begin
			n = n + tz_t'(16);
			v = v >> 16;
		end
		if (v[7:0] == 8'd0) begin
			n = n + tz_t'(8);
			v = v >> 8;
		end
		if (v[3:0] == 4'd0) begin
			n = n + tz_t'(4);
			v = v >> 4;
		end
		if (v[1:0] == 2'd0) begin
			n = n + tz_t'(2);
			v = v >> 2;
		end
		if (v[0] == 1'b0) begin
			n = n + tz_t'(1);
		end
		return n;
	endfunction

endpackage

// File: rtl/bsfn_front.sv
module bsfn_front #(
	parameter int WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bsfn_pkg::size_t   eff_size,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  bsfn_pkg::elem_t   element,
	input  logic              q_full,
	output logic              q_push,
	output bsfn_pkg::cmd_t    q_cmd
);

	// word index by reciprocal multiply, exact for 10-bit indexes
	localparam int RECIP_SH = 20;
	localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;

	logic                  valid_s1;
	bsfn_pkg::cmd_cls_t    cls_s1;
	logic                  want_s1;
	logic                  inr_s1;
	bsfn_pkg::elem_t       elem_s1;
	bsfn_pkg::word_idx_t   word_s1;

	logic                  advance;
	logic [31:0]           prod;
	bsfn_pkg::cmd_cls_t    cls;
	bsfn_pkg::elem_t       word_base;

	assign advance  = !valid_s1 || !q_full;
	assign in_stall = !advance;
	assign prod     = 32'(element) * 32'(RECIP);

	always_comb begin
		case (opcode)
			bsfn_pkg::OP_FILL:       cls = bsfn_pkg::CLS_FILL;
			bsfn_pkg::OP_ADD:        cls = bsfn_pkg::CLS_ADD;
			bsfn_pkg::OP_REMOVE:     cls = bsfn_pkg::CLS_REMOVE;
			bsfn_pkg::OP_TEST:       cls = bsfn_pkg::CLS_TEST;
			bsfn_pkg::OP_FIND_SET,
			bsfn_pkg::OP_FIND_CLEAR: cls = bsfn_pkg::CLS_FIND;
			default:                 cls = bsfn_pkg::CLS_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && advance) begin
			cls_s1  <= cls;
			want_s1 <= (opcode == bsfn_pkg::OP_FIND_SET);
			inr_s1  <= (bsfn_pkg::size_t'(element) < eff_size);
			elem_s1 <= element;
			word_s1 <= prod[RECIP_SH +: bsfn_pkg::WORD_IDX_W];
		end
	end

	assign word_base = bsfn_pkg::elem_t'(32'(word_s1) * 32'(WORD_BITS));

	assign q_push         = valid_s1 && !q_full;
	assign q_cmd.cls      = cls_s1;
	assign q_cmd.want_set = want_s1;
	assign q_cmd.in_range = inr_s1;
	assign q_cmd.element  = elem_s1;
	assign q_cmd.word     = word_s1;
	assign q_cmd.off      = bsfn_pkg::off_t'(elem_s1 - word_base);

endmodule

// File: rtl/bsfn_queue.sv
module bsfn_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsfn_pkg::cmd_t   push_cmd,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output bsfn_pkg::cmd_t   head
);

	bsfn_pkg::cmd_t               ent_q [bsfn_pkg::Q_DEPTH];
	logic [bsfn_pkg::Q_PTR_W-1:0] wr_q;
	logic [bsfn_pkg::Q_PTR_W-1:0] rd_q;
	bsfn_pkg::q_cnt_t             cnt_q;

	assign full  = (cnt_q == bsfn_pkg::q_cnt_t'(bsfn_pkg::Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/bsfn_back.sv
module bsfn_back #(
	parameter int MAX_ELEMS = 1024,
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsfn_pkg::size_t       eff_size,
	input  logic                  q_valid,
	input  bsfn_pkg::cmd_t        q_head,
	output logic                  q_pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic                  is_member,
	output logic                  found,
	output bsfn_pkg::elem_t       position,
	output bsfn_pkg::bk_status_t  status
);

	localparam int NUM_WORDS = (MAX_ELEMS + WORD_BITS - 1) / WORD_BITS;
	localparam int MW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam logic [MW-1:0] LAST_WORD = MW'(NUM_WORDS - 1);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	bsfn_pkg::bk_state_t  state_q, state_d;
	logic [MW-1:0]        clr_q, clr_d;
	logic [MW-1:0]        waddr_q, waddr_d;
	bsfn_pkg::scan_t      base_q, base_d;
	logic [WORD_BITS-1:0] mask_q, mask_d;
	bsfn_pkg::cmd_t       cmd_q, cmd_d;
	logic [WORD_BITS-1:0] rd_q;

	logic                 mem_we;
	logic [MW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic                 mem_re;
	logic [MW-1:0]        mem_ra;

	logic                 res_we;
	logic                 res_member;
	logic                 res_found;
	bsfn_pkg::elem_t      res_pos;

	logic                 out_valid_q;
	logic                 is_member_q;
	logic                 found_q;
	bsfn_pkg::elem_t      position_q;

	logic                 out_free;
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] bit_mask;
	bsfn_pkg::tz_t        tz;
	bsfn_pkg::scan_t      hit_pos;
	bsfn_pkg::scan_t      next_base;
	bsfn_pkg::scan_t      size_ext;

	assign out_free  = !out_valid_q || !out_stall;
	assign cur_word  = (cmd_q.want_set ? rd_q : ~rd_q) & mask_q;
	assign bit_mask  = WORD_BITS'(1) << cmd_q.off;
	assign tz        = bsfn_pkg::ctz64(64'(cur_word));
	assign hit_pos   = base_q + bsfn_pkg::scan_t'(tz);
	assign next_base = base_q + bsfn_pkg::scan_t'(WORD_BITS);
	assign size_ext  = bsfn_pkg::scan_t'(eff_size);

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		waddr_d    = waddr_q;
		base_d     = base_q;
		mask_d     = mask_q;
		cmd_d      = cmd_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = clr_q;
		mem_wd     = '0;
		mem_re     = 1'b0;
		mem_ra     = waddr_q;
		res_we     = 1'b0;
		res_member = 1'b0;
		res_found  = 1'b0;
		res_pos    = '0;
		case (state_q)
			bsfn_pkg::BK_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == LAST_WORD) begin
					clr_d   = '0;
					state_d = bsfn_pkg::BK_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			bsfn_pkg::BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop   = 1'b1;
					cmd_d   = q_head;
					waddr_d = MW'(q_head.word);
					base_d  = bsfn_pkg::scan_t'(q_head.element)
						- bsfn_pkg::scan_t'(q_head.off);
					mask_d  = {WORD_BITS{1'b1}} << q_head.off;
					mem_re  = 1'b1;
					mem_ra  = MW'(q_head.word);
					case (q_head.cls)
						bsfn_pkg::CLS_FILL: begin
							clr_d   = '0;
							state_d = bsfn_pkg::BK_FILL;
						end
						bsfn_pkg::CLS_ADD,
						bsfn_pkg::CLS_REMOVE,
						bsfn_pkg::CLS_TEST: begin
							if (q_head.in_range) begin
								state_d = bsfn_pkg::BK_ACCESS;
							end else begin
								res_we = 1'b1;
							end
						end
						bsfn_pkg::CLS_FIND: begin
							if (q_head.in_range) begin
								state_d = bsfn_pkg::BK_SCAN;
							end else begin
								res_we = 1'b1;
							end
						end
						default: begin
							res_we = 1'b1;
						end
					endcase
				end
			end
			bsfn_pkg::BK_ACCESS: begin
				res_we  = 1'b1;
				state_d = bsfn_pkg::BK_IDLE;
				mem_wa  = waddr_q;
				case (cmd_q.cls)
					bsfn_pkg::CLS_ADD: begin
						mem_we = 1'b1;
						mem_wd = rd_q | bit_mask;
					end
					bsfn_pkg::CLS_REMOVE: begin
						mem_we = 1'b1;
						mem_wd = rd_q & ~bit_mask;
					end
					bsfn_pkg::CLS_TEST: begin
						res_member = ((rd_q & bit_mask) != '0);
					end
					default: begin
					end
				endcase
			end
			bsfn_pkg::BK_SCAN: begin
				if (cur_word != '0) begin
					res_we  = 1'b1;
					state_d = bsfn_pkg::BK_IDLE;
					if (hit_pos < size_ext) begin
						res_found = 1'b1;
						res_pos   = hit_pos[bsfn_pkg::ELEM_W-1:0];
					end
				end else if (next_base >= size_ext) begin
					res_we  = 1'b1;
					state_d = bsfn_pkg::BK_IDLE;
				end else begin
					base_d  = next_base;
					waddr_d = waddr_q + 1'b1;
					mask_d  = '1;
					mem_re  = 1'b1;
					mem_ra  = waddr_q + 1'b1;
				end
			end
			bsfn_pkg::BK_FILL: begin
				mem_we = 1'b1;
				mem_wd = '1;
				if (clr_q == LAST_WORD) begin
					clr_d   = '0;
					res_we  = 1'b1;
					state_d = bsfn_pkg::BK_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			default: begin
				state_d = bsfn_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsfn_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (res_we) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_q <= waddr_d;
		base_q  <= base_d;
		mask_q  <= mask_d;
		cmd_q   <= cmd_d;
		if (res_we) begin
			is_member_q <= res_member;
			found_q     <= res_found;
			position_q  <= res_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign out_valid       = out_valid_q;
	assign is_member       = is_member_q;
	assign found           = found_q;
	assign position        = position_q;
	assign status.clearing = (state_q == bsfn_pkg::BK_CLEAR);
	assign status.pop      = q_pop;

endmodule

// File: rtl/bitmap_set_with_find_next.sv
// Channel   Handshake                Payload
// input     in_valid / in_stall      opcode, element
// result    out_valid / out_stall    is_member, found, position
// config    cfg_valid / cfg_ready    set_size
//
// After reset a clearing pass zeroes the bitmap, one word per cycle
// (16 words at the default size); no item leaves the queue until it ends.
// Each item passes the decode stage and then the queue. The bitmap engine answers an
// out-of-range item or unused opcode as it takes it, does add, remove and test as a word
// read then an access step, and runs find (one word read per cycle) or fill (every word).
// The two-entry queue keeps taking items, until it is full, while the engine is busy or its
// result register is stalled.
module bitmap_set_with_find_next #(
	parameter int MAX_ELEMS = 1024,
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [9:0]  element,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_member,
	output logic        found,
	output logic [9:0]  position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] set_size
);

	bsfn_pkg::size_t      set_size_q;
	bsfn_pkg::size_t      eff_size;
	logic                 q_push;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;
	bsfn_pkg::cmd_t       q_cmd;
	bsfn_pkg::cmd_t       q_head;
	bsfn_pkg::bk_status_t bk_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= bsfn_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			set_size_q <= set_size;
		end
	end

	always_comb begin
		if (int'(set_size_q) > MAX_ELEMS) begin
			eff_size = bsfn_pkg::size_t'(MAX_ELEMS);
		end else begin
			eff_size = set_size_q;
		end
	end

	bsfn_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_size (eff_size),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.element  (element),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	bsfn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	bsfn_back #(
		.MAX_ELEMS (MAX_ELEMS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_size  (eff_size),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.is_member (is_member),
		.found     (found),
		.position  (position),
		.status    (bk_status)
	);

`ifndef NO_ASSERTIONS
	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.clearing |-> !bk_status.pop)
		else $error("queue popped during clearing pass");

	a_member_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_member |-> !found)
		else $error("test and find result mixed");

	a_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("position set without a find hit");

	a_found_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> bsfn_pkg::size_t'(position) < eff_size)
		else $error("found position beyond set size");
`endif

endmodule
